>>> hw/rtl/interval_overlap_join_top_macros.svh
// Assertion macros for the interval overlap join block.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef INTERVAL_OVERLAP_JOIN_TOP_MACROS_SVH
`define INTERVAL_OVERLAP_JOIN_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define IOVJ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iovj: assertion failed");
// Next-cycle implication, disabled while in reset.
`define IOVJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iovj: assertion failed");
`else
`define IOVJ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IOVJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/iovj_pkg.sv
// Shared types and constants for the interval overlap join block.
// No dependencies; used by the controller, datapath and top level.
package iovj_pkg;

    localparam int IOVJ_MAX_SUBJECTS = 64;
    localparam int COORD_W           = 31;
    localparam int QNUM_W            = 16;
    localparam int SUBJ_W            = 7;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/iovj_ctrl.sv
// Controller state machine for the interval overlap join block.
// Depends on iovj_pkg; drives the datapath through ctrl_cmd_t.
module iovj_ctrl import iovj_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  dp_status_t  status,
    output ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        accept     = s_valid && s_ready;
        cmd.clear  = accept && (s_cmd == CMD_CLEAR);
        cmd.load   = accept && (s_cmd == CMD_LOAD);
        cmd.start  = accept && (s_cmd == CMD_QUERY);
        cmd.scan   = (state_reg == S_SCAN);
        cmd.finish = (state_reg == S_FINISH);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.start) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (status.scan_done) state_next = S_FINISH;
            end
            S_FINISH: begin
                if (status.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/iovj_dp.sv
// Datapath for the interval overlap join block: subject table, scan pipeline,
// comparator, held hit and result register. Depends on iovj_pkg and the macros.
`include "interval_overlap_join_top_macros.svh"
module iovj_dp import iovj_pkg::*; #(
    parameter int MAX_SUBJECTS = IOVJ_MAX_SUBJECTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic                cfg_wr,
    input  logic                cfg_mode,
    input  logic [COORD_W-1:0]  s_range_start,
    input  logic [COORD_W-1:0]  s_range_end,
    input  logic [QNUM_W-1:0]   s_query_number,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [QNUM_W-1:0]   m_query_echo,
    output logic [SUBJ_W-1:0]   m_subject_number,
    output logic                m_hit,
    output logic                m_last,
    output logic                m_overflowed
);

    localparam int CW = $clog2(MAX_SUBJECTS + 1);
    localparam int AW = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;

    // Subject table: {start, end}
    logic [2*COORD_W-1:0] mem [MAX_SUBJECTS];

    logic                  mode_reg;
    logic [CW-1:0]         count_reg;
    logic                  overflow_reg;
    logic [CW-1:0]         issue_idx_reg;
    logic                  rd_valid_reg;
    logic [CW-1:0]         rd_idx_reg;
    logic [2*COORD_W-1:0]  rd_data_reg;
    logic                  pend_valid_reg;
    logic [SUBJ_W-1:0]     pend_subj_reg;
    logic [COORD_W-1:0]    qs_reg, qe_reg;
    logic [QNUM_W-1:0]     qn_reg;
    logic                  out_valid_reg;
    logic [QNUM_W-1:0]     out_qn_reg;
    logic [SUBJ_W-1:0]     out_subj_reg;
    logic                  out_hit_reg, out_last_reg, out_ovf_reg;

    logic                  full, issue_more, is_hit, cmp_hit, out_free;
    logic                  stall, advance, rd_en, emit_mid, emit_final;
    logic [COORD_W-1:0]    ss, se;
    logic [SUBJ_W-1:0]     cmp_subj;

    always_comb begin
        full       = (count_reg == CW'(MAX_SUBJECTS));
        issue_more = (issue_idx_reg < count_reg);
        ss         = rd_data_reg[2*COORD_W-1:COORD_W];
        se         = rd_data_reg[COORD_W-1:0];
        is_hit     = mode_reg ? ((qs_reg >= ss) && (qe_reg <= se))
                              : !((qe_reg < ss) || (se < qs_reg));
        cmp_hit    = rd_valid_reg && is_hit;
        cmp_subj   = SUBJ_W'(rd_idx_reg) + SUBJ_W'(1);
        out_free   = !out_valid_reg || m_ready;
        // a second hit cannot retire the held one until the result register frees
        stall      = cmp_hit && pend_valid_reg && !out_free;
        advance    = cmd.scan && !stall;
        rd_en      = advance && issue_more;
        emit_mid   = advance && cmp_hit && pend_valid_reg;
        emit_final = cmd.finish && out_free;
        status.scan_done = !issue_more && !rd_valid_reg;
        status.out_free  = out_free;
    end

    // Table write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            mem[count_reg[AW-1:0]] <= {s_range_start, s_range_end};
        end
        if (rd_en) begin
            rd_data_reg <= mem[issue_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            issue_idx_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) mode_reg <= cfg_mode;

            if (cmd.clear) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end else if (cmd.load) begin
                if (full) overflow_reg <= 1'b1;
                else      count_reg    <= count_reg + CW'(1);
            end

            if (cmd.start) begin
                issue_idx_reg  <= '0;
                rd_valid_reg   <= 1'b0;
                pend_valid_reg <= 1'b0;
            end else if (advance) begin
                if (issue_more) issue_idx_reg <= issue_idx_reg + CW'(1);
                rd_valid_reg <= issue_more;
                if (cmp_hit) pend_valid_reg <= 1'b1;
            end else if (emit_final) begin
                pend_valid_reg <= 1'b0;
            end

            if (emit_mid || emit_final) out_valid_reg <= 1'b1;
            else if (m_ready)           out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            qs_reg <= s_range_start;
            qe_reg <= s_range_end;
            qn_reg <= s_query_number;
        end
        if (advance) rd_idx_reg <= issue_idx_reg;
        if (advance && cmp_hit) pend_subj_reg <= cmp_subj;
        if (emit_mid) begin
            out_qn_reg   <= qn_reg;
            out_subj_reg <= pend_subj_reg;
            out_hit_reg  <= 1'b1;
            out_last_reg <= 1'b0;
            out_ovf_reg  <= overflow_reg;
        end else if (emit_final) begin
            out_qn_reg   <= qn_reg;
            out_subj_reg <= pend_valid_reg ? pend_subj_reg : '0;
            out_hit_reg  <= pend_valid_reg;
            out_last_reg <= 1'b1;
            out_ovf_reg  <= overflow_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_query_echo     = out_qn_reg;
    assign m_subject_number = out_subj_reg;
    assign m_hit            = out_hit_reg;
    assign m_last           = out_last_reg;
    assign m_overflowed     = out_ovf_reg;

    `IOVJ_ASSERT_NEXT(a_stall_holds_scan, aclk, aresetn, stall, $stable(issue_idx_reg))
    `IOVJ_ASSERT_IMPLY(a_overflow_when_full, aclk, aresetn, overflow_reg, full)
    `IOVJ_ASSERT_IMPLY(a_miss_is_last, aclk, aresetn, out_valid_reg && !out_hit_reg,
                       out_last_reg && (out_subj_reg == '0))

endmodule

>>> hw/rtl/interval_overlap_join_top.sv
// Top level of the interval overlap join block.
// Depends on iovj_pkg, iovj_ctrl and iovj_dp.
//
// Holds a table of up to MAX_SUBJECTS closed subject intervals, loaded in order
// with cmd 1 and emptied with cmd 0 (which also clears the sticky overflow
// flag; loads into a full table are dropped and set it). A query (cmd 2) is
// compared with each stored subject in load order: with match_mode 0 a hit is
// any overlap including a shared endpoint, with match_mode 1 the query must lie
// within the subject. One result per hit, 1-based subject number, last set on
// the final one; a query with no hits gives a single result with hit clear.
// Clear, load and unused commands leave the controller idle. A query is paced
// by the single read port of the subject table (one subject compared per cycle
// while the scan is not stalled) plus a step each for the table read, the end
// of scan and the final result. The scan stalls while a second hit waits for a
// busy result register; the final result waits for it too. While a query
// runs no new request is taken; the last result may still sit in the output
// register as the next request is accepted. The user must write match_mode
// (cfg channel, always ready) only while idle; the block does not enforce it.
module interval_overlap_join_top import iovj_pkg::*; #(
    parameter int MAX_SUBJECTS = IOVJ_MAX_SUBJECTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_match_mode,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [COORD_W-1:0]  s_range_start,
    input  logic [COORD_W-1:0]  s_range_end,
    input  logic [QNUM_W-1:0]   s_query_number,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [QNUM_W-1:0]   m_query_echo,
    output logic [SUBJ_W-1:0]   m_subject_number,
    output logic                m_hit,
    output logic                m_last,
    output logic                m_overflowed
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // config register can always be written
    assign cfg_ready = 1'b1;

    iovj_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .status  (status),
        .cmd     (cmd)
    );

    iovj_dp #(
        .MAX_SUBJECTS (MAX_SUBJECTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_mode         (cfg_match_mode),
        .s_range_start    (s_range_start),
        .s_range_end      (s_range_end),
        .s_query_number   (s_query_number),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_query_echo     (m_query_echo),
        .m_subject_number (m_subject_number),
        .m_hit            (m_hit),
        .m_last           (m_last),
        .m_overflowed     (m_overflowed)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for interval_overlap_join_top: directed and random requests.
// Depends on iovj_pkg and the interval_overlap_join_top RTL; nothing else.
module tb import iovj_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [QNUM_W-1:0]  qnum_t;

    // one result of a query, as the block should report it
    typedef struct {
        qnum_t             query_echo;
        logic [SUBJ_W-1:0] subject_number;
        logic              hit;
        logic              last;
        logic              overflowed;
    } join_result_t;

    localparam int         MAX_SUBJECTS  = IOVJ_MAX_SUBJECTS;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic       MODE_OVERLAP  = 1'b0;
    localparam logic       MODE_CONTAIN  = 1'b1;
    localparam coord_t     COORD_MAX     = '1;
    localparam int         MAX_GAP       = 14;
    // spare cycles waited before a match_mode write
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_CYCLES  = 80;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         RANDOM_ITEMS  = 170;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_match_mode;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_cmd;
    coord_t            s_range_start;
    coord_t            s_range_end;
    qnum_t             s_query_number;
    logic              m_valid;
    logic              m_ready;
    qnum_t             m_query_echo;
    logic [SUBJ_W-1:0] m_subject_number;
    logic              m_hit;
    logic              m_last;
    logic              m_overflowed;

    interval_overlap_join_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_match_mode   (cfg_match_mode),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_range_start    (s_range_start),
        .s_range_end      (s_range_end),
        .s_query_number   (s_query_number),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_query_echo     (m_query_echo),
        .m_subject_number (m_subject_number),
        .m_hit            (m_hit),
        .m_last           (m_last),
        .m_overflowed     (m_overflowed)
    );

    // Shadow copy of the subject table and the mode register
    coord_t       table_starts [MAX_SUBJECTS];
    coord_t       table_ends   [MAX_SUBJECTS];
    int           table_count;
    logic         table_overflow;
    logic         join_mode;

    join_result_t pending_results [$];
    int           errors;
    int           idle_cycles;
    int           stall_left;
    bit           no_idle;    // set for stretches run at full rate on both sides
    coord_t       window_base;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor: applies one accepted request to the shadow table and
    // queues the results that it should produce.
    // ---------------------------------------------------------------
    function automatic logic subject_matches(coord_t qs, coord_t qe, coord_t ss, coord_t se);
        if (join_mode == MODE_CONTAIN)
            return (qs >= ss) && (qe <= se);
        // closed intervals: touching at an endpoint counts
        return !((qe < ss) || (se < qs));
    endfunction

    function automatic void predict_join(logic [1:0] cmd, coord_t qs, coord_t qe, qnum_t qn);
        join_result_t hits [$];
        join_result_t r;
        case (cmd)
            CMD_CLEAR: begin
                table_count    = 0;
                table_overflow = 1'b0;
            end
            CMD_LOAD: begin
                if (table_count < MAX_SUBJECTS) begin
                    table_starts[table_count] = qs;
                    table_ends[table_count]   = qe;
                    table_count++;
                end else begin
                    table_overflow = 1'b1;
                end
            end
            CMD_QUERY: begin
                r.query_echo = qn;
                r.overflowed = table_overflow;
                r.last       = 1'b0;
                for (int j = 0; j < table_count; j++) begin
                    if (subject_matches(qs, qe, table_starts[j], table_ends[j])) begin
                        r.subject_number = SUBJ_W'(j + 1);
                        r.hit            = 1'b1;
                        hits.insert(hits.size(), r);
                    end
                end
                if (hits.size() == 0) begin
                    // a miss still answers with one result
                    r.subject_number = '0;
                    r.hit            = 1'b0;
                    hits.insert(hits.size(), r);
                end
                hits[hits.size() - 1].last = 1'b1;
                foreach (hits[i]) pending_results.insert(pending_results.size(), hits[i]);
            end
            default: ;  // unused command: no effect
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Request channel. The task is entered just after the previous
    // request was taken; with no gap, valid simply stays high and the
    // payload moves on at the falling edge.
    // ---------------------------------------------------------------
    task automatic send_request(input logic [1:0] cmd, input coord_t rs, input coord_t re,
                                input qnum_t qn);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_range_start  <= rs;
        s_range_end    <= re;
        s_query_number <= qn;
        do @(posedge aclk); while (!s_ready);
        predict_join(cmd, rs, re, qn);
    endtask

    // drop valid after the last request taken, so it is not taken twice
    task automatic release_request();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // match_mode is only changed with the block idle and every result in
    task automatic write_match_mode(input logic mode);
        release_request();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_match_mode <= mode;
        do @(posedge aclk); while (!cfg_ready);
        join_mode = mode;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result channel: after each result is taken, ready is held low for a drawn
    // number of cycles, then high until the next result is taken.
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        join_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: query_echo %0d subject_number %0d",
                       m_query_echo, m_subject_number);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("query_echo",     want.query_echo,     m_query_echo);
                check_field("subject_number", want.subject_number, m_subject_number);
                check_field("hit",            want.hit,            m_hit);
                check_field("last",           want.last,           m_last);
                check_field("overflowed",     want.overflowed,     m_overflowed);
            end
            stall_left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Random content helpers
    // ---------------------------------------------------------------
    function automatic qnum_t rand_qnum();
        return qnum_t'($urandom_range(1, 65535));
    endfunction

    // mostly near a common base so that intervals overlap, sometimes anywhere
    function automatic coord_t rand_coord();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return window_base + coord_t'($urandom_range(0, 255));
        if (sel < 9)
            return coord_t'($urandom);
        return $urandom_range(0, 1) ? COORD_MAX : coord_t'(0);
    endfunction

    function automatic coord_t rand_end(coord_t s);
        int unsigned len;
        if ($urandom_range(0, 6) == 0)
            return rand_coord();    // unrelated end, often reversed
        len = $urandom_range(0, 64);
        if (s > COORD_MAX - coord_t'(len))
            return COORD_MAX;
        return s + coord_t'(len);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_empty_query();
        // table is empty after reset
        send_request(CMD_QUERY, '0, COORD_MAX, qnum_t'(1));
        send_request(CMD_QUERY, COORD_MAX, '0, qnum_t'(16'hFFFF));
    endtask

    task automatic test_overlap_edges();
        send_request(CMD_LOAD, '0, '0, rand_qnum());
        send_request(CMD_LOAD, COORD_MAX, COORD_MAX, rand_qnum());
        send_request(CMD_LOAD, coord_t'(100), coord_t'(200), rand_qnum());
        send_request(CMD_LOAD, coord_t'(300), coord_t'(300), rand_qnum());
        // shares one endpoint with the third subject and one with the fourth
        send_request(CMD_QUERY, coord_t'(200), coord_t'(300), qnum_t'(2));
        // covers everything
        send_request(CMD_QUERY, '0, COORD_MAX, qnum_t'(3));
        // falls in the hole between subjects
        send_request(CMD_QUERY, coord_t'(201), coord_t'(299), qnum_t'(4));
    endtask

    task automatic test_reversed_interval();
        send_request(CMD_LOAD, coord_t'(500), coord_t'(400), rand_qnum());
        send_request(CMD_QUERY, coord_t'(450), coord_t'(450), qnum_t'(5));
        send_request(CMD_QUERY, coord_t'(350), coord_t'(150), qnum_t'(6));
    endtask

    task automatic test_unused_cmd();
        send_request(CMD_UNUSED, COORD_MAX, COORD_MAX, qnum_t'(16'hFFFF));
        send_request(CMD_QUERY, coord_t'(150), coord_t'(150), qnum_t'(7));
    endtask

    task automatic test_containment();
        write_match_mode(MODE_CONTAIN);
        send_request(CMD_QUERY, coord_t'(150), coord_t'(160), qnum_t'(8));
        send_request(CMD_QUERY, '0, COORD_MAX, qnum_t'(9));
        send_request(CMD_QUERY, COORD_MAX, COORD_MAX, qnum_t'(10));
        send_request(CMD_QUERY, coord_t'(100), coord_t'(200), qnum_t'(11));
    endtask

    task automatic test_clear();
        send_request(CMD_CLEAR, rand_coord(), rand_coord(), rand_qnum());
        send_request(CMD_QUERY, '0, COORD_MAX, qnum_t'(12));
    endtask

    // fill past capacity, then query a full table and clear the flag
    task automatic test_overflow();
        coord_t s;
        write_match_mode(MODE_OVERLAP);
        window_base = coord_t'($urandom_range(0, 32'h7FFF_FE00));
        no_idle = 1'b1;
        repeat (MAX_SUBJECTS + 3) begin
            s = rand_coord();
            send_request(CMD_LOAD, s, rand_end(s), rand_qnum());
        end
        no_idle = 1'b0;
        send_request(CMD_QUERY, '0, COORD_MAX, rand_qnum());   // every subject hits
        repeat (3) begin
            s = rand_coord();
            send_request(CMD_QUERY, s, rand_end(s), rand_qnum());
        end
        send_request(CMD_CLEAR, rand_coord(), rand_coord(), rand_qnum());
        send_request(CMD_QUERY, '0, COORD_MAX, rand_qnum());
    endtask

    // mostly clear / load / query runs with random content, some loose noise
    task automatic test_random_mix();
        int         sent;
        int         n_loads;
        int         n_queries;
        coord_t     s;
        logic [1:0] cmd;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                write_match_mode(logic'($urandom_range(0, 1)));
            no_idle     = ($urandom_range(0, 4) == 0);
            window_base = coord_t'($urandom_range(0, 32'h7FFF_FE00));
            if ($urandom_range(0, 6) != 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_request(CMD_CLEAR, rand_coord(), rand_coord(), rand_qnum());
                    sent++;
                end
                if ($urandom_range(0, 9) == 0)
                    n_loads = $urandom_range(20, MAX_SUBJECTS + 2);
                else
                    n_loads = $urandom_range(1, 8);
                repeat (n_loads) begin
                    s = rand_coord();
                    send_request(CMD_LOAD, s, rand_end(s), rand_qnum());
                    sent++;
                end
                n_queries = $urandom_range(1, 6);
                repeat (n_queries) begin
                    s = rand_coord();
                    send_request(CMD_QUERY, s, rand_end(s), rand_qnum());
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    cmd = 2'($urandom_range(0, 3));
                    send_request(cmd, rand_coord(), rand_coord(), rand_qnum());
                    if (cmd != CMD_UNUSED)
                        sent++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_match_mode = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = CMD_CLEAR;
        s_range_start  = '0;
        s_range_end    = '0;
        s_query_number = '0;
        m_ready        = 1'b0;
        stall_left     = 0;
        errors         = 0;
        idle_cycles    = 0;
        no_idle        = 1'b0;
        window_base    = '0;
        table_count    = 0;
        table_overflow = 1'b0;
        join_mode      = MODE_OVERLAP;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_query();
        test_overlap_edges();
        test_reversed_interval();
        test_unused_cmd();
        test_containment();
        test_clear();
        test_overflow();
        test_random_mix();

        // drain: the watchdog covers a block that never finishes
        release_request();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
